// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the basic block former.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Concurrent check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// File: hw/rtl/bbf_pkg.sv
// Shared types and constants of the MIPS basic block former.
// Used by bbf_decode, bbf_former and mips_basic_block_former_core; depends on nothing.
package bbf_pkg;

	// Block length limit; the block closes once this many words are taken.
	localparam int unsigned BBF_MAX_INSTRUCTIONS = 32;

	// Field widths.
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned PAGE_W  = 20;

	// Stream widths.
	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 16;

	// Primary opcodes and function codes used by the classifier.
	localparam logic [5:0] OP_SPECIAL  = 6'h00;
	localparam logic [5:0] OP_REGIMM   = 6'h01;
	localparam logic [5:0] OP_J        = 6'h02;
	localparam logic [5:0] OP_BGTZ     = 6'h07;
	localparam logic [5:0] OP_COP0     = 6'h10;
	localparam logic [5:0] OP_COP2     = 6'h12;
	localparam logic [5:0] OP_BEQL     = 6'h14;
	localparam logic [5:0] OP_BGTZL    = 6'h17;
	localparam logic [5:0] OP_LDL      = 6'h1A;
	localparam logic [5:0] OP_LDR      = 6'h1B;
	localparam logic [5:0] OP_OP1E     = 6'h1E;
	localparam logic [5:0] OP_OP1F     = 6'h1F;
	localparam logic [5:0] OP_MEM_BASE = 6'h20;
	localparam logic [5:0] FN_JR       = 6'h08;
	localparam logic [5:0] FN_JALR     = 6'h09;
	localparam logic [5:0] FN_SYSCALL  = 6'h0C;
	localparam logic [5:0] FN_BREAK    = 6'h0D;
	localparam logic [4:0] RS_BC       = 5'h08;
	localparam logic [31:0] WORD_ERET  = 32'h4200_0018;

	// One accepted instruction request.
	typedef struct packed {
		logic              first;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] instruction_word;
		logic              readable;
	} item_t;

	// Opcode class flags of one word.
	typedef struct packed {
		logic is_memory;
		logic is_coprocessor;
		logic is_branch;
		logic is_stop;
	} class_t;

	// One result.
	typedef struct packed {
		logic               instr_valid;
		logic [POS_W-1:0]   position;
		logic               is_memory;
		logic               is_coprocessor;
		logic               is_branch;
		logic               is_stop;
		logic               in_delay_slot;
		logic               last;
		logic [COUNT_W-1:0] block_count;
	} result_t;

endpackage

// File: hw/rtl/bbf_decode.sv
// Opcode classifier of the MIPS basic block former.
// Depends on bbf_pkg for the opcode constants and class_t.
module bbf_decode (
	input  logic [bbf_pkg::WORD_W-1:0] word,
	output bbf_pkg::class_t            cls
);
	import bbf_pkg::*;

	logic [5:0] op;
	logic [4:0] rs;
	logic [5:0] fn;
	logic       cop_op;

	assign op     = word[31:26];
	assign rs     = word[25:21];
	assign fn     = word[5:0];
	assign cop_op = (op >= OP_COP0) && (op <= OP_COP2);

	// Loads and stores, including the unaligned and extended forms.
	assign cls.is_memory = (op >= OP_MEM_BASE) || (op == OP_LDL) || (op == OP_LDR) ||
		(op == OP_OP1E) || (op == OP_OP1F);

	assign cls.is_coprocessor = cop_op;

	// Register jumps, REGIMM, J..BGTZ, likely branches and coprocessor branches.
	assign cls.is_branch = ((op == OP_SPECIAL) && ((fn == FN_JR) || (fn == FN_JALR))) ||
		(op == OP_REGIMM) || ((op >= OP_J) && (op <= OP_BGTZ)) ||
		((op >= OP_BEQL) && (op <= OP_BGTZL)) || (cop_op && (rs == RS_BC));

	// Syscall, break and the return-from-exception word end a block.
	assign cls.is_stop = ((op == OP_SPECIAL) && ((fn == FN_SYSCALL) || (fn == FN_BREAK))) ||
		(word == WORD_ERET);

endmodule

// File: hw/rtl/bbf_former.sv
// Block state and result logic of the MIPS basic block former.
// Depends on bbf_pkg and instantiates bbf_decode.
module bbf_former #(
	parameter int unsigned MAX_INSTRUCTIONS = bbf_pkg::BBF_MAX_INSTRUCTIONS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  bbf_pkg::item_t   item,
	output logic             res_valid,
	output bbf_pkg::result_t res
);
	import bbf_pkg::*;

	localparam logic [COUNT_W:0] MaxCount = (COUNT_W+1)'(MAX_INSTRUCTIONS);

	logic [PAGE_W-1:0]  page_q;
	logic [COUNT_W-1:0] count_q;
	logic               delay_q;
	logic               open_q;

	logic [PAGE_W-1:0]  page_d;
	logic [COUNT_W-1:0] count_d;
	logic               delay_d;
	logic               open_d;

	class_t             cls;
	logic [PAGE_W-1:0]  item_page;
	logic               bad_start;
	logic               page_break;
	logic [COUNT_W-1:0] base_count;
	logic               base_delay;
	logic [COUNT_W:0]   next_count;
	logic               is_last;

	bbf_decode u_decode (
		.word (item.instruction_word),
		.cls  (cls)
	);

	assign item_page  = item.address[ADDR_W-1:ADDR_W-PAGE_W];
	assign bad_start  = (item.address[1:0] != 2'b00) || !item.readable;
	assign page_break = (item_page != page_q) || !item.readable;

	// A fresh block starts from zero; a continuing one from the stored state.
	assign base_count = item.first ? '0 : count_q;
	assign base_delay = item.first ? 1'b0 : delay_q;
	assign next_count = {1'b0, base_count} + 1'b1;
	assign is_last    = base_delay || cls.is_stop || (next_count >= MaxCount);

	// Result and next state for the request under work.
	always_comb begin
		page_d    = page_q;
		count_d   = count_q;
		delay_d   = delay_q;
		open_d    = open_q;
		res_valid = 1'b0;
		res       = '0;
		if (item.first && bad_start) begin
			// Empty block: terminator with no instructions.
			page_d    = item_page;
			count_d   = '0;
			delay_d   = 1'b0;
			open_d    = 1'b0;
			res_valid = 1'b1;
			res.last  = 1'b1;
		end else if (!item.first && !open_q) begin
			// Nothing open: the word is dropped.
			res_valid = 1'b0;
		end else if (!item.first && page_break) begin
			// Page crossing or unreadable word closes the block.
			open_d           = 1'b0;
			delay_d          = 1'b0;
			res_valid        = 1'b1;
			res.last         = 1'b1;
			res.block_count  = count_q;
		end else begin
			// The word is taken into the block.
			if (item.first) begin
				page_d = item_page;
			end
			res_valid          = 1'b1;
			res.instr_valid    = 1'b1;
			res.position       = base_count[POS_W-1:0];
			res.is_memory      = cls.is_memory;
			res.is_coprocessor = cls.is_coprocessor;
			res.is_branch      = cls.is_branch;
			res.is_stop        = cls.is_stop;
			res.in_delay_slot  = base_delay;
			res.last           = is_last;
			res.block_count    = next_count[COUNT_W-1:0];
			count_d            = next_count[COUNT_W-1:0];
			open_d             = !is_last;
			delay_d            = !is_last && cls.is_branch;
		end
	end

	// Block state registers, updated when a request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= '0;
			count_q <= '0;
			delay_q <= 1'b0;
			open_q  <= 1'b0;
		end else if (step) begin
			page_q  <= page_d;
			count_q <= count_d;
			delay_q <= delay_d;
			open_q  <= open_d;
		end
	end

endmodule

// File: hw/rtl/mips_basic_block_former_core.sv
// Top level of the MIPS basic block former: input register, block former, result register.
// Depends on bbf_pkg, bbf_former (with bbf_decode) and assert_macros.svh.
//
// Takes one fetched instruction word per cycle on the slave stream while the master stream
// does not stall, and emits at most one result per word on the master stream, grouping
// words into basic blocks that open on a request marked first and close on a stop, after
// a branch delay slot, at MAX_INSTRUCTIONS words (32 by default), on a 4 KiB page change
// or an unreadable word. Throughput is one word per clock without back-pressure; a result
// passes the input register, then the result register; the block state is updated as a
// request moves between them. The input side keeps accepting while a result waits, as long
// as the input register can move on; words that arrive with no block open produce no result.
module mips_basic_block_former_core #(
	parameter int unsigned MAX_INSTRUCTIONS = bbf_pkg::BBF_MAX_INSTRUCTIONS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: address [31:0], instruction_word [63:32]
	input  logic [bbf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// tuser: first [0], readable [1]
	input  logic [bbf_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: position [4:0], is_memory [5], is_coprocessor [6], is_branch [7],
	//        is_stop [8], in_delay_slot [9], block_count [15:10]
	output logic [bbf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// tuser: instr_valid [0]
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast
);
	import bbf_pkg::*;

	`include "assert_macros.svh"

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;

	logic    advance;
	logic    res_valid;
	result_t res;

	// The input register moves on when the result register is free or being drained.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.first            <= s_axis_tuser[0];
			item_s1.readable         <= s_axis_tuser[1];
			item_s1.address          <= s_axis_tdata[ADDR_W-1:0];
			item_s1.instruction_word <= s_axis_tdata[ADDR_W+WORD_W-1:ADDR_W];
		end
	end

	bbf_former #(
		.MAX_INSTRUCTIONS (MAX_INSTRUCTIONS)
	) u_former (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.instr_valid;
	assign m_axis_tlast  = res_s2.last;
	assign m_axis_tdata  = {res_s2.block_count, res_s2.in_delay_slot, res_s2.is_stop,
		res_s2.is_branch, res_s2.is_coprocessor, res_s2.is_memory, res_s2.position};

	// A terminator always ends its block.
	`ASSERT_IMPLY(a_term_last, valid_s2 && !res_s2.instr_valid, res_s2.last,
		"terminator without last")
	// A delay-slot instruction always closes the block.
	`ASSERT_IMPLY(a_slot_last, valid_s2 && res_s2.in_delay_slot, res_s2.last,
		"delay slot not last")
	// An instruction's position is one below the running count.
	`ASSERT_IMPLY(a_pos_count, valid_s2 && res_s2.instr_valid,
		res_s2.position == POS_W'(res_s2.block_count - 1'b1), "position and count disagree")

endmodule
